/* rtl/upe_pkg.sv */
// Package for the UTF-8 percent encoder: widths, queue entry type,
// character constants and the byte classification helpers.
// No dependencies.
`default_nettype none

package upe_pkg;

    localparam int CP_W        = 21;
    localparam int CHAR_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int MAX_BYTES   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_PCT  = 7'h25;  // '%'
    localparam logic [CHAR_W-1:0] CHAR_DASH = 7'h2D;  // '-'

    // One encoded code point: UTF-8 bytes in order, index of the last byte,
    // and the end-of-text flag.
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [1:0]                       last_idx;
        logic                             text_end;
    } upe_entry_t;

    // Queue occupancy seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } upe_q_stat_t;

    // Letter, digit or dash: the byte goes out unescaped.
    function automatic logic passes_through(input logic [BYTE_W-1:0] b);
        logic is_digit;
        logic is_upper;
        logic is_lower;
        begin
            is_digit = (b >= 8'h30) && (b <= 8'h39);
            is_upper = (b >= 8'h41) && (b <= 8'h5A);
            is_lower = (b >= 8'h61) && (b <= 8'h7A);
            return is_digit || is_upper || is_lower || (b == {1'b0, CHAR_DASH});
        end
    endfunction

    // Uppercase hex digit for one nibble.
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
        begin
            if (n < 4'd10)
            begin
                return 7'h30 + {3'b000, n};
            end
            return 7'h37 + {3'b000, n};
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/upe_ifs.sv */
// Channel interfaces of the UTF-8 percent encoder: code point input and
// character output, each with valid/ready. Depends on upe_pkg.
`default_nettype none

interface upe_cp_if;
    logic                     valid;
    logic                     ready;
    logic [upe_pkg::CP_W-1:0] code_point;
    logic                     text_end;

    modport source (output valid, output code_point, output text_end, input ready);
    modport sink   (input valid, input code_point, input text_end, output ready);
endinterface

interface upe_char_if;
    logic                       valid;
    logic                       ready;
    logic [upe_pkg::CHAR_W-1:0] out_char;
    logic                       run_last;
    logic                       text_done;

    modport source (output valid, output out_char, output run_last, output text_done,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input text_done,
                    output ready);
endinterface

`default_nettype wire

/* rtl/upe_front.sv */
// Front end: accept a code point and split it into UTF-8 bytes for the queue.
// Depends on upe_pkg and upe_ifs.
`default_nettype none

module upe_front (
    upe_cp_if.sink                code,
    input  upe_pkg::upe_q_stat_t  q_stat,
    output logic                  push,
    output upe_pkg::upe_entry_t   entry
);
    import upe_pkg::*;

    logic [CP_W-1:0] cp;

    assign cp         = code.code_point;
    assign code.ready = !q_stat.full;
    assign push       = code.valid && !q_stat.full;

    always_comb
    begin
        entry          = '0;
        entry.text_end = code.text_end;
        if (cp <= 21'h00007F)
        begin
            entry.bytes[0] = {1'b0, cp[6:0]};
            entry.last_idx = 2'd0;
        end
        else if (cp <= 21'h0007FF)
        begin
            entry.bytes[0] = {3'b110, cp[10:6]};
            entry.bytes[1] = {2'b10, cp[5:0]};
            entry.last_idx = 2'd1;
        end
        else if (cp <= 21'h00FFFF)
        begin
            entry.bytes[0] = {4'b1110, cp[15:12]};
            entry.bytes[1] = {2'b10, cp[11:6]};
            entry.bytes[2] = {2'b10, cp[5:0]};
            entry.last_idx = 2'd2;
        end
        else
        begin
            entry.bytes[0] = {5'b11110, cp[20:18]};
            entry.bytes[1] = {2'b10, cp[17:12]};
            entry.bytes[2] = {2'b10, cp[11:6]};
            entry.bytes[3] = {2'b10, cp[5:0]};
            entry.last_idx = 2'd3;
        end
    end

endmodule

`default_nettype wire

/* rtl/upe_queue.sv */
// Short queue of encoded code points between front and back end.
// Depends on upe_pkg.
`default_nettype none

module upe_queue #(
    parameter int Depth = upe_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  upe_pkg::upe_entry_t  wr_entry,
    input  logic                 pop,
    output upe_pkg::upe_entry_t  head,
    output upe_pkg::upe_q_stat_t q_stat
);
    import upe_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    upe_entry_t      mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign q_stat.full  = (count_reg == FullCnt);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/upe_back.sv */
// Back end: walk the head entry's bytes, one output character per cycle
// unless stalled, into a registered output stage. Depends on upe_pkg, upe_ifs.
`default_nettype none

module upe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  upe_pkg::upe_entry_t  head,
    input  upe_pkg::upe_q_stat_t q_stat,
    output logic                 pop,
    upe_char_if.source           chars
);
    import upe_pkg::*;

    localparam logic [1:0] PH_FIRST = 2'd0;  // pass-through byte or '%'
    localparam logic [1:0] PH_HI    = 2'd1;  // high hex digit
    localparam logic [1:0] PH_LO    = 2'd2;  // low hex digit

    logic [1:0]        byte_idx_reg, byte_idx_next;
    logic [1:0]        phase_reg, phase_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              run_last_reg, run_last_next;
    logic              text_done_reg, text_done_next;

    logic [BYTE_W-1:0] cur_byte;
    logic              is_plain;
    logic              byte_done;
    logic              entry_done;
    logic              advance;
    logic              emit;
    logic [CHAR_W-1:0] cur_char;

    assign cur_byte   = head.bytes[byte_idx_reg];
    assign is_plain   = passes_through(cur_byte);
    assign byte_done  = is_plain || (phase_reg == PH_LO);
    assign entry_done = byte_done && (byte_idx_reg == head.last_idx);
    assign advance    = !valid_reg || chars.ready;
    assign emit       = advance && !q_stat.empty;
    assign pop        = emit && entry_done;

    always_comb
    begin
        case (phase_reg)
            PH_FIRST: cur_char = is_plain ? cur_byte[CHAR_W-1:0] : CHAR_PCT;
            PH_HI:    cur_char = hex_char(cur_byte[7:4]);
            PH_LO:    cur_char = hex_char(cur_byte[3:0]);
            default:  cur_char = CHAR_PCT;
        endcase
    end

    always_comb
    begin
        byte_idx_next  = byte_idx_reg;
        phase_next     = phase_reg;
        valid_next     = valid_reg;
        char_next      = char_reg;
        run_last_next  = run_last_reg;
        text_done_next = text_done_reg;
        if (advance)
        begin
            valid_next = !q_stat.empty;
        end
        if (emit)
        begin
            char_next      = cur_char;
            run_last_next  = entry_done;
            text_done_next = entry_done && head.text_end;
            if (entry_done)
            begin
                byte_idx_next = '0;
                phase_next    = PH_FIRST;
            end
            else if (byte_done)
            begin
                byte_idx_next = byte_idx_reg + 1'b1;
                phase_next    = PH_FIRST;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= '0;
            phase_reg    <= PH_FIRST;
            valid_reg    <= 1'b0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            phase_reg    <= phase_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        run_last_reg  <= run_last_next;
        text_done_reg <= text_done_next;
    end

    assign chars.valid     = valid_reg;
    assign chars.out_char  = char_reg;
    assign chars.run_last  = run_last_reg;
    assign chars.text_done = text_done_reg;

endmodule

`default_nettype wire

/* rtl/utf8_percent_encoder.sv */
// UTF-8 percent encoder, top level: front end, queue and back end.
// Depends on upe_pkg, upe_ifs, upe_front, upe_queue and upe_back.
//
// Usage
//   code  : one transaction per Unicode code point (21 bits) plus text_end.
//   chars : one transaction per ASCII output character, with run_last on the
//           final character of a code point and text_done where that code
//           point also carried text_end.
//   Each code point is split into 1 to 4 UTF-8 bytes; letters, digits and
//   '-' pass as one character, every other byte becomes '%' and two
//   uppercase hex digits, so a code point gives 1 to 12 characters.
// Ordering and throughput
//   When the queue is empty, a code point is first written into the queue,
//   then its first character into the output register. The back end
//   sequencer issues one character per cycle while the queue holds an
//   entry and the output is not stalled; the front end takes a new code
//   point every cycle while the queue has room.
// Reset
//   rst_n clears the queue pointers, the sequencer and the output valid;
//   nothing else needs clearing.
// Stalls
//   When chars.ready is low the output register holds its character; the
//   queue keeps filling until full, then code.ready drops.
`default_nettype none

module utf8_percent_encoder #(
    parameter int QueueDepth = upe_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    upe_cp_if.sink     code,
    upe_char_if.source chars
);
    import upe_pkg::*;

    upe_entry_t  wr_entry;
    upe_entry_t  head;
    upe_q_stat_t q_stat;
    logic        push;
    logic        pop;

    // Classify and split the incoming code point.
    upe_front u_front (
        .code   (code),
        .q_stat (q_stat),
        .push   (push),
        .entry  (wr_entry)
    );

    // Decouple acceptance from character issue.
    upe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // Issue characters, advance through bytes, drop the entry when done.
    upe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .chars  (chars)
    );

endmodule

`default_nettype wire

/* rtl/upe_checker.sv */
// Port-level checks for the UTF-8 percent encoder, bound to the top level.
// Depends on upe_pkg and utf8_percent_encoder.
`default_nettype none

module upe_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [upe_pkg::CHAR_W-1:0] out_char,
    input wire logic                       run_last,
    input wire logic                       text_done
);
    import upe_pkg::*;

    // A stalled transaction keeps its valid.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    // A stalled character holds.
    a_hold_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_char))
        else $error("output character changed while stalled");

    // End of text only on the last character of a run.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_done |-> run_last)
        else $error("text_done without run_last");

    // A '%' always opens an escape, so it never ends a run.
    a_pct_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char == CHAR_PCT) |-> !run_last)
        else $error("run ended on an escape marker");

endmodule

bind utf8_percent_encoder upe_checker u_upe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_char  (chars.out_char),
    .run_last  (chars.run_last),
    .text_done (chars.text_done)
);

`default_nettype wire
